/* design/crcsbel_pkg.sv */
// ----------------------------------------------------------------------------
// crcsbel_pkg
// Shared types, constants and the CRC32C byte table for the bit error locator.
// ----------------------------------------------------------------------------
package crcsbel_pkg;

    localparam int          SYN_W   = 32;
    localparam int          LEN_W   = 17;
    localparam int          POS_W   = 19;
    localparam int          BYTE_W  = 16;
    localparam int          BIT_W   = 3;
    localparam int          LANES   = 8;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [7:0]  TOP_BIT  = 8'h80;

    typedef enum logic [1:0] {
        STS_FOUND   = 2'd0,
        STS_CLEAN   = 2'd1,
        STS_BAD_LEN = 2'd2,
        STS_MULTI   = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    // sequencer -> lane unit
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

    // lane unit -> sequencer
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
    } t_lane_sts;

    // Reflected CRC32C table entry
    function automatic logic [31:0] crc_tab(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

/* design/crcsbel_lanes.sv */
// ----------------------------------------------------------------------------
// crcsbel_lanes
// Eight single-bit syndrome lanes, advanced one zero byte per step and
// compared against the held target syndrome.
// ----------------------------------------------------------------------------
module crcsbel_lanes (
    input  logic                            i_clk,
    input  crcsbel_pkg::t_lane_ctl          i_ctl,
    input  logic [crcsbel_pkg::SYN_W-1:0]   i_syndrome,
    output crcsbel_pkg::t_lane_sts          o_sts
);

    logic [crcsbel_pkg::SYN_W-1:0] r_lane [crcsbel_pkg::LANES];
    logic [crcsbel_pkg::SYN_W-1:0] r_target;
    logic [crcsbel_pkg::LANES-1:0] w_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_target <= i_syndrome;
            for (int j = 0; j < crcsbel_pkg::LANES; j++) begin
                r_lane[j] <= crcsbel_pkg::crc_tab(crcsbel_pkg::TOP_BIT >> j);
            end
        end else if (i_ctl.step) begin
            // zero-byte advance: T[s & 0xFF] ^ (s >> 8)
            for (int j = 0; j < crcsbel_pkg::LANES; j++) begin
                r_lane[j] <= crcsbel_pkg::crc_tab(r_lane[j][7:0])
                             ^ {8'd0, r_lane[j][31:8]};
            end
        end
    end

    always_comb begin
        o_sts = '0;
        for (int j = 0; j < crcsbel_pkg::LANES; j++) begin
            w_match[j] = (r_lane[j] == r_target);
        end
        // lowest j wins
        for (int j = crcsbel_pkg::LANES - 1; j >= 0; j--) begin
            if (w_match[j]) begin
                o_sts.hit     = 1'b1;
                o_sts.hit_bit = crcsbel_pkg::BIT_W'(j);
            end
        end
    end

endmodule

/* design/crcsbel_ctrl.sv */
// ----------------------------------------------------------------------------
// crcsbel_ctrl
// Sequencer: length and zero-syndrome checks, byte position walk from last
// byte to first, and the result register.
// ----------------------------------------------------------------------------
module crcsbel_ctrl #(
    parameter int MAX_BYTES = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [crcsbel_pkg::SYN_W-1:0]    i_syndrome,
    input  logic [crcsbel_pkg::LEN_W-1:0]    i_buf_len,
    output crcsbel_pkg::t_lane_ctl           o_ctl,
    input  crcsbel_pkg::t_lane_sts           i_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output crcsbel_pkg::t_status             o_status,
    output logic [crcsbel_pkg::POS_W-1:0]    o_bit_pos,
    output logic [crcsbel_pkg::BYTE_W-1:0]   o_byte_index,
    output logic [crcsbel_pkg::BIT_W-1:0]    o_bit_in_byte
);

    crcsbel_pkg::t_state                r_state, n_state;
    logic [crcsbel_pkg::LEN_W-1:0]      r_pos, n_pos;
    logic                               r_out_valid, n_out_valid;
    crcsbel_pkg::t_status               r_status, n_status;
    logic [crcsbel_pkg::POS_W-1:0]      r_bit_pos, n_bit_pos;
    logic [crcsbel_pkg::BYTE_W-1:0]     r_byte_index, n_byte_index;
    logic [crcsbel_pkg::BIT_W-1:0]      r_bit_in_byte, n_bit_in_byte;
    logic                               w_out_free;
    logic                               w_bad_len;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_ready    = (r_state == crcsbel_pkg::ST_IDLE) && w_out_free;
    assign w_bad_len  = (i_buf_len == '0)
                        || ({15'd0, i_buf_len} > 32'(MAX_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crcsbel_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_status      <= n_status;
        r_bit_pos     <= n_bit_pos;
        r_byte_index  <= n_byte_index;
        r_bit_in_byte <= n_bit_in_byte;
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_bit_pos     = r_bit_pos;
        n_byte_index  = r_byte_index;
        n_bit_in_byte = r_bit_in_byte;
        o_ctl         = '0;
        case (r_state)
            crcsbel_pkg::ST_IDLE: begin
                if (i_valid && o_ready) begin
                    if (w_bad_len || i_syndrome == '0) begin
                        n_out_valid   = 1'b1;
                        n_status      = w_bad_len ? crcsbel_pkg::STS_BAD_LEN
                                                  : crcsbel_pkg::STS_CLEAN;
                        n_bit_pos     = '0;
                        n_byte_index  = '0;
                        n_bit_in_byte = '0;
                    end else begin
                        o_ctl.load = 1'b1;
                        n_pos      = i_buf_len - 1'b1;
                        n_state    = crcsbel_pkg::ST_WALK;
                    end
                end
            end
            crcsbel_pkg::ST_WALK: begin
                if (i_sts.hit) begin
                    if (w_out_free) begin
                        n_out_valid   = 1'b1;
                        n_status      = crcsbel_pkg::STS_FOUND;
                        n_bit_pos     = {r_pos[crcsbel_pkg::BYTE_W-1:0], i_sts.hit_bit};
                        n_byte_index  = r_pos[crcsbel_pkg::BYTE_W-1:0];
                        n_bit_in_byte = i_sts.hit_bit;
                        n_state       = crcsbel_pkg::ST_IDLE;
                    end
                end else if (r_pos == '0) begin
                    if (w_out_free) begin
                        n_out_valid   = 1'b1;
                        n_status      = crcsbel_pkg::STS_MULTI;
                        n_bit_pos     = '0;
                        n_byte_index  = '0;
                        n_bit_in_byte = '0;
                        n_state       = crcsbel_pkg::ST_IDLE;
                    end
                end else begin
                    o_ctl.step = 1'b1;
                    n_pos      = r_pos - 1'b1;
                end
            end
            default: begin
                n_state = crcsbel_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_bit_pos     = r_bit_pos;
    assign o_byte_index  = r_byte_index;
    assign o_bit_in_byte = r_bit_in_byte;

    a_ctl_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.load, o_ctl.step}))
        else $error("lane load and step together");

    a_bad_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_buf_len == '0)
        |=> (r_out_valid && r_status == crcsbel_pkg::STS_BAD_LEN))
        else $error("zero length not reported");

    a_pos_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crcsbel_pkg::ST_WALK) |-> ({15'd0, r_pos} < 32'(MAX_BYTES)))
        else $error("walk position beyond buffer bound");

    a_zero_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != crcsbel_pkg::STS_FOUND)
        |-> (r_bit_pos == '0 && r_byte_index == '0 && r_bit_in_byte == '0))
        else $error("position fields set without a located bit");

endmodule

/* design/crc32c_single_bit_error_locator_unit.sv */
// Locates a single flipped bit from a CRC32C syndrome. A zero or oversize
// length, or a zero syndrome, gives its result the cycle after the word is
// taken. Otherwise eight bit syndromes are walked from the last byte to the
// first, one byte position per cycle through the eight-lane zero-byte
// advance unit; the input is not ready while a walk runs. One result word
// is produced per input word; the input is also held off while a result
// word waits in the output register, though a new word can be taken at the
// edge that drains it.
// ----------------------------------------------------------------------------
// crc32c_single_bit_error_locator_unit
// Top level: stream ports, sequencer and shared lane unit.
// ----------------------------------------------------------------------------
module crc32c_single_bit_error_locator_unit #(
    parameter int MAX_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // syndrome[31:0], buf_len[48:32], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // bit_pos[18:0], byte_index[34:19],
                                        // bit_in_byte[37:35], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    crcsbel_pkg::t_lane_ctl                 w_ctl;
    crcsbel_pkg::t_lane_sts                 w_sts;
    crcsbel_pkg::t_status                   w_status;
    logic [crcsbel_pkg::POS_W-1:0]          w_bit_pos;
    logic [crcsbel_pkg::BYTE_W-1:0]         w_byte_index;
    logic [crcsbel_pkg::BIT_W-1:0]          w_bit_in_byte;

    crcsbel_ctrl #(
        .MAX_BYTES (MAX_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_syndrome    (s_axis_tdata[31:0]),
        .i_buf_len     (s_axis_tdata[48:32]),
        .o_ctl         (w_ctl),
        .i_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (w_status),
        .o_bit_pos     (w_bit_pos),
        .o_byte_index  (w_byte_index),
        .o_bit_in_byte (w_bit_in_byte)
    );

    crcsbel_lanes u_lanes (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_syndrome (s_axis_tdata[31:0]),
        .o_sts      (w_sts)
    );

    assign m_axis_tdata = {2'b00, w_bit_in_byte, w_byte_index, w_bit_pos};
    assign m_axis_tuser = w_status;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the CRC32C single-bit error locator. Syndrome and length words
// go in on the slave stream; each is predicted by walking eight bit syndromes
// back from the last byte. Result words are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int LEN_LIMIT   = 65536;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        crcsbel_pkg::t_status                status;
        logic [crcsbel_pkg::POS_W-1:0]       pos;
        logic [crcsbel_pkg::BYTE_W-1:0]      byte_idx;
        logic [crcsbel_pkg::BIT_W-1:0]       bit_idx;
    } t_loc_result;

    class locator_scoreboard;
        logic [31:0] crc_table [256];
        t_loc_result awaited[$];
        int          mismatches;

        function new();
            logic [31:0] v;
            mismatches = 0;
            for (int i = 0; i < 256; i++) begin
                v = i;
                for (int k = 0; k < 8; k++) begin
                    v = v[0] ? ((v >> 1) ^ crcsbel_pkg::CRC_POLY) : (v >> 1);
                end
                crc_table[i] = v;
            end
        endfunction

        // one zero byte through the reflected CRC
        function logic [31:0] advance(logic [31:0] s);
            return crc_table[s[7:0]] ^ (s >> 8);
        endfunction

        function t_loc_result locate(logic [31:0] syn,
                                     logic [crcsbel_pkg::LEN_W-1:0] len);
            t_loc_result r;
            logic [31:0] lane [crcsbel_pkg::LANES];
            int          b;
            bit          hit;
            r.status   = crcsbel_pkg::STS_MULTI;
            r.pos      = '0;
            r.byte_idx = '0;
            r.bit_idx  = '0;
            hit        = 1'b0;
            if (len == 0 || len > LEN_LIMIT) begin
                r.status = crcsbel_pkg::STS_BAD_LEN;
            end else if (syn == 0) begin
                r.status = crcsbel_pkg::STS_CLEAN;
            end else begin
                for (int j = 0; j < crcsbel_pkg::LANES; j++) begin
                    lane[j] = crc_table[crcsbel_pkg::TOP_BIT >> j];
                end
                b = len;
                while (b > 0 && !hit) begin
                    b--;
                    // lowest j wins on the byte where a match turns up
                    for (int j = 0; j < crcsbel_pkg::LANES && !hit; j++) begin
                        if (lane[j] == syn) begin
                            hit        = 1'b1;
                            r.status   = crcsbel_pkg::STS_FOUND;
                            r.byte_idx = crcsbel_pkg::BYTE_W'(b);
                            r.bit_idx  = crcsbel_pkg::BIT_W'(j);
                            r.pos      = crcsbel_pkg::POS_W'(b * 8 + j);
                        end
                    end
                    if (!hit) begin
                        for (int j = 0; j < crcsbel_pkg::LANES; j++) begin
                            lane[j] = advance(lane[j]);
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_word(logic [31:0] syn, logic [crcsbel_pkg::LEN_W-1:0] len);
            awaited.push_back(locate(syn, len));
        endfunction

        function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(logic [39:0] data, logic [1:0] user);
            t_loc_result want;
            if (awaited.size() == 0) begin
                $display("%0t: result word expected none, got tdata %h tuser %h",
                         $time, data, user);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 32'(want.status), 32'(user));
            compare_field("bit_pos", 32'(want.pos), 32'(data[18:0]));
            compare_field("byte_index", 32'(want.byte_idx), 32'(data[34:19]));
            compare_field("bit_in_byte", 32'(want.bit_idx), 32'(data[37:35]));
            compare_field("pad", 32'd0, 32'(data[39:38]));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // syndrome[31:0], buf_len[48:32], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // bit_pos[18:0], byte_index[34:19],
                                       // bit_in_byte[37:35], zero pad
    logic [1:0]  m_axis_tuser;         // status[1:0]

    locator_scoreboard sb;
    bit gaps_on = 1'b1;
    int big_left = 3;
    int idle_cycles = 0;

    crc32c_single_bit_error_locator_unit #(
        .MAX_BYTES(LEN_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 28);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_word(s_axis_tdata[31:0], s_axis_tdata[48:32]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tdata, m_axis_tuser);
        end
    end

    // a full-length walk accepts nothing while it runs; the stall watchdog allows for it
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [31:0] syn,
                             input logic [crcsbel_pkg::LEN_W-1:0] len);
        while (gaps_on && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, len, syn};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // syndrome of a lone flip of bit j (from the MSB) in byte b of a len-byte buffer
    function automatic logic [31:0] flip_syndrome(int unsigned byte_no, int unsigned bit_no,
                                                  int unsigned len);
        logic [31:0] s;
        s = sb.crc_table[crcsbel_pkg::TOP_BIT >> bit_no];
        repeat (len - 1 - byte_no) s = sb.advance(s);
        return s;
    endfunction

    // mostly short buffers, a rare full-size one
    function automatic int unsigned pick_len();
        if (big_left > 0 && $urandom_range(99) < 3) begin
            big_left--;
            return LEN_LIMIT;
        end
        if ($urandom_range(9) == 0) return $urandom_range(1024, 1);
        return $urandom_range(40, 1);
    endfunction

    initial begin
        int unsigned len;
        int unsigned k;
        logic [31:0] syn;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length checks come before the syndrome
        send_word(32'd0, 17'd0);
        send_word(32'hDEAD_BEEF, 17'd0);
        send_word(32'h1234_5678, 17'd65537);
        send_word(32'hFFFF_FFFF, 17'h1FFFF);
        send_word(32'd0, 17'd1);
        send_word(32'd0, 17'd65536);
        send_word(flip_syndrome(0, 0, 1), 17'd1);
        send_word(flip_syndrome(0, 7, 1), 17'd1);
        send_word(flip_syndrome(5, 3, 9), 17'd9);
        send_word(flip_syndrome(65535, 2, 65536), 17'd65536);
        send_word(flip_syndrome(0, 7, 65536), 17'd65536);
        send_word(32'hFFFF_FFFF, 17'd1);
        send_word(32'hFFFF_FFFF, 17'd65536);
        // flip lies further back than the buffer reaches
        send_word(flip_syndrome(0, 4, 12), 17'd6);
        send_word(flip_syndrome(1, 1, 4) ^ flip_syndrome(2, 6, 4), 17'd4);
        send_word(32'h8000_0000, 17'd3);
        send_word(32'h0000_0001, 17'd3);

        for (int n = 0; n < 100; n++) begin
            gaps_on = !(n >= 40 && n < 70);
            k = $urandom_range(99);
            if (k < 55) begin
                len = pick_len();
                syn = flip_syndrome($urandom_range(len - 1), $urandom_range(7), len);
            end else if (k < 65) begin
                len = pick_len();
                syn = flip_syndrome($urandom_range(len - 1), $urandom_range(7), len) ^
                      flip_syndrome($urandom_range(len - 1), $urandom_range(7), len);
            end else if (k < 75) begin
                len = pick_len();
                syn = $urandom();
            end else if (k < 83) begin
                len = pick_len();
                syn = '0;
            end else begin
                len = $urandom_range(1) ? 0 : $urandom_range(131071, 65537);
                syn = $urandom_range(1) ? $urandom() : 32'd0;
            end
            send_word(syn, crcsbel_pkg::LEN_W'(len));
        end
        s_axis_tvalid <= 1'b0;
        gaps_on = 1'b1;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* files.f */
design/crcsbel_pkg.sv
design/crcsbel_lanes.sv
design/crcsbel_ctrl.sv
design/crc32c_single_bit_error_locator_unit.sv
verif/tb.sv
